/* design/sprb_pkg.sv */
// sprb_pkg: shared types and constants for the sparse palette run blitter
// no dependencies; used by sparse_palette_run_blitter_unit
package sprb_pkg;

  // request operation codes
  typedef enum logic [1:0] {
    OP_PALETTE = 2'd0,
    OP_START   = 2'd1,
    OP_PAYLOAD = 2'd2
  } op_e;

  // configuration register indexes
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam int unsigned CFG_W   = 15;
  localparam int unsigned POS_W   = 28;
  localparam int unsigned RUN_W   = 10;
  localparam int unsigned COORD_W = 32;

  localparam logic [CFG_W-1:0]   WIDTH_RESET  = 15'd640;
  localparam logic [CFG_W-1:0]   HEIGHT_RESET = 15'd480;
  localparam logic [COORD_W-1:0] END_WORD     = 32'hFFFF_FFFF;
  localparam logic [COORD_W-1:0] ALPHA_TOGGLE = 32'h0018_0000;
  localparam logic [7:0]         OPAQUE_ALPHA = 8'hFF;

endpackage

/* design/sparse_palette_run_blitter_unit.sv */
// sparse_palette_run_blitter_unit: run-length palette blitter, parser and output pipeline
// depends on sprb_pkg
//
// usage:
//  - input channel (in_valid_i / in_stall_o) takes one request per cycle unless stalled:
//    a palette write, a block start carrying the start cursor, or one payload byte
//  - every payload byte gives exactly one result on the output channel
//    (out_valid_o / out_stall_i); palette writes and block starts give none
//  - a result carries a pixel write (linear index and colour), the block end flag
//    or neither, plus the sticky zero-length segment error
//  - throughput: one request per cycle unless the output stalls, whatever the request mix
//  - pipeline: stage a registers the request and reads the palette, stage b runs
//    the parser, stage c forms row times width, stage d adds the column and
//    presents the result
//  - when the output holds a result and out_stall_i is high, the whole pipeline
//    freezes and in_stall_o goes high in the same cycle
//  - reset clears the pipeline, sets width 640 and height 480, and leaves the parser
//    idle until a block start; palette contents are undefined until written
//  - configuration writes (cfg_we_i) are only legal while no request is in flight
module sparse_palette_run_blitter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [sprb_pkg::CFG_W-1:0]    cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    operation_i,
  input  logic [7:0]                    palette_index_i,
  input  logic [31:0]                   palette_color_i,
  input  logic signed [31:0]            start_x_i,
  input  logic signed [31:0]            start_y_i,
  input  logic [7:0]                    data_byte_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          pixel_valid_o,
  output logic [sprb_pkg::POS_W-1:0]    pixel_index_o,
  output logic [31:0]                   pixel_value_o,
  output logic                          block_end_o,
  output logic                          bad_size_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CONTROL,
    PH_ALPHA,
    PH_INDEX,
    PH_SKIP
  } phase_e;

  localparam int unsigned CW = sprb_pkg::COORD_W;
  localparam int unsigned RW = sprb_pkg::RUN_W;
  localparam int unsigned WW = sprb_pkg::CFG_W;
  localparam int unsigned PW = sprb_pkg::POS_W;

  // pipeline advance: everything moves unless a finished result is held back
  logic pipe_en;
  logic in_accept;

  assign pipe_en    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !pipe_en;
  assign in_accept  = in_valid_i && pipe_en;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [WW-1:0] width_q, width_d;
  logic [WW-1:0] height_q, height_d;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        sprb_pkg::CFG_IDX_WIDTH:  width_d  = cfg_data_i;
        sprb_pkg::CFG_IDX_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sprb_pkg::WIDTH_RESET;
      height_q <= sprb_pkg::HEIGHT_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage a: request register and palette memory
  // ---------------------------------------------------------------------------
  logic [31:0] palette_mem [256];
  logic [31:0] a_color_q;
  logic        a_valid_q;
  logic [1:0]  a_op_q;
  logic [CW-1:0] a_start_x_q;
  logic [CW-1:0] a_start_y_q;
  logic [7:0]  a_byte_q;

  // palette write and palette read of the incoming byte share the accept edge;
  // a later request always sees an earlier write
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      if (operation_i == sprb_pkg::OP_PALETTE) begin
        palette_mem[palette_index_i] <= palette_color_i;
      end
      a_color_q <= palette_mem[data_byte_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (pipe_en) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_op_q      <= operation_i;
      a_start_x_q <= $unsigned(start_x_i);
      a_start_y_q <= $unsigned(start_y_i);
      a_byte_q    <= data_byte_i;
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: run parser
  // ---------------------------------------------------------------------------
  phase_e        phase_q, phase_d;
  logic [CW-1:0] cursor_x_q, cursor_x_d;
  logic [CW-1:0] cursor_y_q, cursor_y_d;
  logic          alpha_mode_q, alpha_mode_d;
  logic [23:0]   ctrl_bytes_q, ctrl_bytes_d;
  logic [1:0]    ctrl_count_q, ctrl_count_d;
  logic [RW-1:0] run_left_q, run_left_d;
  logic [RW-1:0] seg_left_q, seg_left_d;
  logic [RW:0]   skip_left_q, skip_left_d;
  logic [PW-1:0] row_q, row_d;
  logic [WW-1:0] col_q, col_d;
  logic [7:0]    alpha_hold_q, alpha_hold_d;
  logic          size_err_q, size_err_d;

  logic          b_valid_q, b_valid_d;
  logic          b_pix_q, b_pix_d;
  logic [PW-1:0] b_row_q, b_row_d;
  logic [WW-1:0] b_col_q, b_col_d;
  logic [31:0]   b_value_q, b_value_d;
  logic          b_end_q, b_end_d;
  logic          b_err_q, b_err_d;

  logic          is_payload;
  logic [CW-1:0] ctrl_word;
  logic          ctrl_last;
  logic          ctrl_fire;
  logic [CW-1:0] ctrl_dx;

  assign is_payload = a_valid_q && (a_op_q == sprb_pkg::OP_PAYLOAD);
  assign ctrl_word  = {a_byte_q, ctrl_bytes_q};
  assign ctrl_last  = (phase_q == PH_CONTROL) && (ctrl_count_q == 2'd3);
  assign ctrl_fire  = ctrl_last && (ctrl_word != sprb_pkg::END_WORD);
  // bits 31..21 are a signed x step
  assign ctrl_dx    = {{(CW-11){ctrl_word[31]}}, ctrl_word[31:21]};

  // segment start inputs: a new control word moves the cursor first
  logic [CW-1:0] seg_x_in;
  logic [CW-1:0] seg_y_in;
  logic [RW-1:0] seg_run;
  logic          seg_alpha;

  assign seg_x_in  = ctrl_fire ? cursor_x_q + ctrl_dx : cursor_x_q;
  assign seg_y_in  = ctrl_fire ? cursor_y_q + {{(CW-9){1'b0}}, ctrl_word[8:0]} : cursor_y_q;
  assign seg_run   = ctrl_fire ? ctrl_word[18:9] : run_left_q;
  assign seg_alpha = ctrl_fire ? (alpha_mode_q ^ ((ctrl_word & sprb_pkg::ALPHA_TOGGLE) != '0))
                               : alpha_mode_q;

  // segment start: wrap x into the row, carry whole rows into y, clip at row end
  logic [CW-1:0] seg_carry;
  logic [CW-1:0] seg_y;
  logic [RW-1:0] seg_wx;
  logic [WW-1:0] seg_wx_ext;
  logic [WW-1:0] seg_room;
  logic [RW-1:0] seg_size;
  logic          seg_off;
  logic [RW:0]   seg_x_end;

  assign seg_carry  = {{RW{seg_x_in[CW-1]}}, seg_x_in[CW-1:RW]};
  assign seg_y      = seg_y_in + seg_carry;
  assign seg_wx     = seg_x_in[RW-1:0];
  assign seg_wx_ext = {{(WW-RW){1'b0}}, seg_wx};
  assign seg_room   = width_q - seg_wx_ext;
  assign seg_x_end  = {1'b0, seg_wx} + {1'b0, seg_size};

  always_comb begin
    if (seg_wx_ext > width_q) begin
      seg_size = seg_run;
    end else if (seg_room < {{(WW-RW){1'b0}}, seg_run}) begin
      seg_size = seg_room[RW-1:0];
    end else begin
      seg_size = seg_run;
    end
  end

  // negative rows and rows at or past the height are off-image
  assign seg_off = (seg_wx_ext >= width_q) || seg_y[CW-1] ||
                   (seg_y >= {{(CW-WW){1'b0}}, height_q});

  logic          seg_go;
  logic [RW-1:0] seg_left_dec;
  logic [RW:0]   skip_dec;
  logic [7:0]    pix_alpha;

  assign seg_left_dec = seg_left_q - 1'b1;
  assign skip_dec     = (skip_left_q != '0) ? skip_left_q - 1'b1 : skip_left_q;
  // stored alpha is (2a - 1) mod 256
  assign pix_alpha    = alpha_mode_q ? ({alpha_hold_q[6:0], 1'b0} - 8'd1)
                                     : sprb_pkg::OPAQUE_ALPHA;

  always_comb begin
    phase_d      = phase_q;
    cursor_x_d   = cursor_x_q;
    cursor_y_d   = cursor_y_q;
    alpha_mode_d = alpha_mode_q;
    ctrl_bytes_d = ctrl_bytes_q;
    ctrl_count_d = ctrl_count_q;
    run_left_d   = run_left_q;
    seg_left_d   = seg_left_q;
    skip_left_d  = skip_left_q;
    row_d        = row_q;
    col_d        = col_q;
    alpha_hold_d = alpha_hold_q;
    size_err_d   = size_err_q;
    seg_go       = 1'b0;
    b_pix_d      = 1'b0;
    b_row_d      = '0;
    b_col_d      = '0;
    b_value_d    = '0;
    b_end_d      = 1'b0;

    if (a_valid_q && (a_op_q == sprb_pkg::OP_START)) begin
      cursor_x_d   = a_start_x_q;
      cursor_y_d   = a_start_y_q;
      alpha_mode_d = 1'b1;
      phase_d      = PH_CONTROL;
      ctrl_bytes_d = '0;
      ctrl_count_d = '0;
      run_left_d   = '0;
      seg_left_d   = '0;
      skip_left_d  = '0;
      size_err_d   = 1'b0;
    end else if (is_payload) begin
      unique case (phase_q)
        PH_CONTROL: begin
          if (!ctrl_last) begin
            case (ctrl_count_q)
              2'd0:    ctrl_bytes_d[7:0]   = ctrl_bytes_q[7:0]   | a_byte_q;
              2'd1:    ctrl_bytes_d[15:8]  = ctrl_bytes_q[15:8]  | a_byte_q;
              default: ctrl_bytes_d[23:16] = ctrl_bytes_q[23:16] | a_byte_q;
            endcase
            ctrl_count_d = ctrl_count_q + 2'd1;
          end else begin
            ctrl_count_d = '0;
            ctrl_bytes_d = '0;
            if (!ctrl_fire) begin
              b_end_d = 1'b1;
              phase_d = PH_IDLE;
            end else begin
              alpha_mode_d = seg_alpha;
              cursor_x_d   = seg_x_in;
              cursor_y_d   = seg_y_in;
              run_left_d   = seg_run;
              seg_go       = 1'b1;
            end
          end
        end
        PH_ALPHA: begin
          alpha_hold_d = a_byte_q;
          phase_d      = PH_INDEX;
        end
        PH_INDEX: begin
          b_pix_d    = 1'b1;
          b_row_d    = row_q;
          b_col_d    = col_q;
          b_value_d  = a_color_q | {pix_alpha, 24'h0};
          col_d      = col_q + 1'b1;
          seg_left_d = seg_left_dec;
          if (seg_left_dec == '0) begin
            seg_go = 1'b1;
          end else begin
            phase_d = alpha_mode_q ? PH_ALPHA : PH_INDEX;
          end
        end
        PH_SKIP: begin
          skip_left_d = skip_dec;
          if (skip_dec == '0) begin
            seg_go = 1'b1;
          end
        end
        default: ;
      endcase

      if (seg_go) begin
        if (seg_run == '0) begin
          // run used up: next control word
          phase_d      = PH_CONTROL;
          ctrl_count_d = '0;
          ctrl_bytes_d = '0;
        end else begin
          cursor_x_d = {{(CW-RW){1'b0}}, seg_wx};
          cursor_y_d = seg_y;
          if (seg_size == '0) begin
            // zero-length segment abandons the block
            size_err_d = 1'b1;
            phase_d    = PH_IDLE;
          end else begin
            cursor_x_d = {{(CW-RW-1){1'b0}}, seg_x_end};
            run_left_d = seg_run - seg_size;
            row_d      = seg_y[PW-1:0];
            col_d      = seg_wx_ext;
            if (seg_off) begin
              skip_left_d = seg_alpha ? {seg_size, 1'b0} : {1'b0, seg_size};
              phase_d     = PH_SKIP;
            end else begin
              seg_left_d = seg_size;
              phase_d    = seg_alpha ? PH_ALPHA : PH_INDEX;
            end
          end
        end
      end
    end

    b_valid_d = is_payload;
    b_err_d   = size_err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      cursor_x_q   <= '0;
      cursor_y_q   <= '0;
      alpha_mode_q <= 1'b1;
      ctrl_bytes_q <= '0;
      ctrl_count_q <= '0;
      run_left_q   <= '0;
      seg_left_q   <= '0;
      skip_left_q  <= '0;
      row_q        <= '0;
      col_q        <= '0;
      alpha_hold_q <= '0;
      size_err_q   <= 1'b0;
      b_valid_q    <= 1'b0;
      b_pix_q      <= 1'b0;
      b_row_q      <= '0;
      b_col_q      <= '0;
      b_value_q    <= '0;
      b_end_q      <= 1'b0;
      b_err_q      <= 1'b0;
    end else if (pipe_en) begin
      phase_q      <= phase_d;
      cursor_x_q   <= cursor_x_d;
      cursor_y_q   <= cursor_y_d;
      alpha_mode_q <= alpha_mode_d;
      ctrl_bytes_q <= ctrl_bytes_d;
      ctrl_count_q <= ctrl_count_d;
      run_left_q   <= run_left_d;
      seg_left_q   <= seg_left_d;
      skip_left_q  <= skip_left_d;
      row_q        <= row_d;
      col_q        <= col_d;
      alpha_hold_q <= alpha_hold_d;
      size_err_q   <= size_err_d;
      b_valid_q    <= b_valid_d;
      b_pix_q      <= b_pix_d;
      b_row_q      <= b_row_d;
      b_col_q      <= b_col_d;
      b_value_q    <= b_value_d;
      b_end_q      <= b_end_d;
      b_err_q      <= b_err_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage c: row base = row times width
  // ---------------------------------------------------------------------------
  logic [PW+WW-1:0] row_prod;
  logic             c_valid_q;
  logic             c_pix_q;
  logic [PW-1:0]    c_base_q;
  logic [WW-1:0]    c_col_q;
  logic [31:0]      c_value_q;
  logic             c_end_q;
  logic             c_err_q;

  assign row_prod = {{WW{1'b0}}, b_row_q} * {{PW{1'b0}}, width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (pipe_en) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      c_pix_q   <= b_pix_q;
      c_base_q  <= row_prod[PW-1:0];
      c_col_q   <= b_col_q;
      c_value_q <= b_value_q;
      c_end_q   <= b_end_q;
      c_err_q   <= b_err_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage d: linear index and result register
  // ---------------------------------------------------------------------------
  logic [PW-1:0] d_index;
  logic          d_valid_q;
  logic          d_pix_q;
  logic [PW-1:0] d_index_q;
  logic [31:0]   d_value_q;
  logic          d_end_q;
  logic          d_err_q;

  assign d_index = c_base_q + {{(PW-WW){1'b0}}, c_col_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (pipe_en) begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      d_pix_q   <= c_pix_q;
      d_index_q <= d_index;
      d_value_q <= c_value_q;
      d_end_q   <= c_end_q;
      d_err_q   <= c_err_q;
    end
  end

  assign out_valid_o   = d_valid_q;
  assign pixel_valid_o = d_pix_q;
  assign pixel_index_o = d_index_q;
  assign pixel_value_o = d_value_q;
  assign block_end_o   = d_end_q;
  assign bad_size_o    = d_err_q;

`ifndef NO_ASSERTIONS
  // the input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // a result is never both a pixel and a block end
  a_pix_end_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(pixel_valid_o && block_end_o))
    else $error("pixel and block end in one result");

  // a result without a pixel carries zero index and value
  a_nopix_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !pixel_valid_o) |-> (pixel_index_o == '0 && pixel_value_o == '0))
    else $error("non-pixel result carries pixel data");

  // the skip phase always has bytes left to drop
  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP) |-> (skip_left_q != '0))
    else $error("skip phase with empty skip count");
`endif

endmodule

/* tb/sprb_result_check.sv */
// sprb_result_check: tracks the blitter requests, predicts every payload result and
// compares it with the output channel; depends on sprb_pkg
`timescale 1ns / 100ps

module sprb_result_check (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [sprb_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [1:0]                 operation_i,
  input  logic [7:0]                 palette_index_i,
  input  logic [31:0]                palette_color_i,
  input  logic [31:0]                start_x_i,
  input  logic [31:0]                start_y_i,
  input  logic [7:0]                 data_byte_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic                       pixel_valid_i,
  input  logic [sprb_pkg::POS_W-1:0] pixel_index_i,
  input  logic [31:0]                pixel_value_i,
  input  logic                       block_end_i,
  input  logic                       bad_size_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int unsigned PW = sprb_pkg::POS_W;
  localparam int unsigned RW = sprb_pkg::RUN_W;

  typedef enum logic [2:0] {P_IDLE, P_CONTROL, P_ALPHA, P_INDEX, P_SKIP} parse_e;

  typedef struct packed {
    logic          pix_valid;
    logic [PW-1:0] pix_index;
    logic [31:0]   pix_value;
    logic          blk_end;
    logic          size_err;
  } pixel_result_t;

  logic [31:0]   colour_lut [256];
  logic [31:0]   img_w, img_h;
  logic [31:0]   cur_x, cur_y;
  logic          alpha_on;
  parse_e        parse_st;
  logic [23:0]   ctl_bytes;
  logic [1:0]    ctl_cnt;
  logic [RW-1:0] run_rem, seg_rem;
  logic [10:0]   skip_rem;
  logic [PW-1:0] wr_pos;
  logic [7:0]    alpha_byte;
  logic          size_err;

  pixel_result_t pixel_expect_q[$];

  // cut the next piece of the run at the row end, or go back to control words
  function automatic void open_segment();
    logic [31:0] carry, span;
    logic        off_img;
    if (run_rem == '0) begin
      parse_st  = P_CONTROL;
      ctl_cnt   = '0;
      ctl_bytes = '0;
      return;
    end
    carry = 32'($signed(cur_x) >>> 10);
    cur_y = cur_y + carry;
    cur_x = cur_x & 32'd1023;
    if (cur_x > img_w)
      span = 32'(run_rem);
    else if (img_w - cur_x < 32'(run_rem))
      span = img_w - cur_x;
    else
      span = 32'(run_rem);
    if (span == 32'd0) begin
      size_err = 1'b1;
      parse_st = P_IDLE;
      return;
    end
    off_img = cur_x >= img_w || cur_y[31] || cur_y >= img_h;
    wr_pos  = PW'(cur_x + cur_y * img_w);
    run_rem = run_rem - RW'(span);
    cur_x   = cur_x + span;
    if (off_img) begin
      skip_rem = alpha_on ? 11'(2 * span) : 11'(span);
      parse_st = P_SKIP;
    end else begin
      seg_rem  = RW'(span);
      parse_st = alpha_on ? P_ALPHA : P_INDEX;
    end
  endfunction

  // one payload byte through the parser
  function automatic pixel_result_t blit_byte(logic [7:0] b);
    pixel_result_t r;
    logic [31:0]   word, dx;
    logic [7:0]    top;
    r = '0;
    case (parse_st)
      P_CONTROL: begin
        if (ctl_cnt < 2'd3) begin
          ctl_bytes = ctl_bytes | (24'(b) << (8 * ctl_cnt));
          ctl_cnt++;
        end else begin
          word      = {b, ctl_bytes};
          ctl_cnt   = '0;
          ctl_bytes = '0;
          if (word == sprb_pkg::END_WORD) begin
            r.blk_end = 1'b1;
            parse_st  = P_IDLE;
          end else begin
            if ((word & sprb_pkg::ALPHA_TOGGLE) != '0)
              alpha_on = !alpha_on;
            dx      = {{21{word[31]}}, word[31:21]};
            cur_x   = cur_x + dx;
            cur_y   = cur_y + {23'd0, word[8:0]};
            run_rem = word[18:9];
            open_segment();
          end
        end
      end
      P_ALPHA: begin
        alpha_byte = b;
        parse_st   = P_INDEX;
      end
      P_INDEX: begin
        top = alpha_on ? 8'({alpha_byte[6:0], 1'b0} - 8'd1) : sprb_pkg::OPAQUE_ALPHA;
        r.pix_valid = 1'b1;
        r.pix_index = wr_pos;
        r.pix_value = colour_lut[b] | {top, 24'd0};
        wr_pos  = wr_pos + 1'b1;
        seg_rem = seg_rem - 1'b1;
        if (seg_rem == '0)
          open_segment();
        else
          parse_st = alpha_on ? P_ALPHA : P_INDEX;
      end
      P_SKIP: begin
        if (skip_rem != '0)
          skip_rem--;
        if (skip_rem == '0)
          open_segment();
      end
      default: ;
    endcase
    r.size_err = size_err;
    return r;
  endfunction

  function automatic int report_diff(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pixel_result_t want;
    pixel_result_t fresh;
    int            fails;
    if (!rst_ni) begin
      img_w      = 32'(sprb_pkg::WIDTH_RESET);
      img_h      = 32'(sprb_pkg::HEIGHT_RESET);
      cur_x      = '0;
      cur_y      = '0;
      alpha_on   = 1'b1;
      parse_st   = P_IDLE;
      ctl_bytes  = '0;
      ctl_cnt    = '0;
      run_rem    = '0;
      seg_rem    = '0;
      skip_rem   = '0;
      wr_pos     = '0;
      alpha_byte = '0;
      size_err   = 1'b0;
      pixel_expect_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      fails = fail_count_o;
      if (cfg_we_i) begin
        if (cfg_index_i == sprb_pkg::CFG_IDX_WIDTH)
          img_w = 32'(cfg_data_i);
        else
          img_h = 32'(cfg_data_i);
      end
      // results first: anything accepted now belongs to an older request
      if (out_valid_i && !out_stall_i) begin
        if (pixel_expect_q.size() == 0) begin
          $error("result with nothing pending: index 0x%0h value 0x%0h",
                 pixel_index_i, pixel_value_i);
          fails++;
        end else begin
          want = pixel_expect_q.pop_front();
          fails += report_diff("pixel_valid", 32'(want.pix_valid), 32'(pixel_valid_i));
          fails += report_diff("pixel_index", 32'(want.pix_index), 32'(pixel_index_i));
          fails += report_diff("pixel_value", want.pix_value, pixel_value_i);
          fails += report_diff("block_end", 32'(want.blk_end), 32'(block_end_i));
          fails += report_diff("bad_size", 32'(want.size_err), 32'(bad_size_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (operation_i)
          sprb_pkg::OP_PALETTE: colour_lut[palette_index_i] = palette_color_i;
          sprb_pkg::OP_START: begin
            cur_x     = start_x_i;
            cur_y     = start_y_i;
            alpha_on  = 1'b1;
            parse_st  = P_CONTROL;
            ctl_bytes = '0;
            ctl_cnt   = '0;
            run_rem   = '0;
            seg_rem   = '0;
            skip_rem  = '0;
            size_err  = 1'b0;
          end
          sprb_pkg::OP_PAYLOAD: begin
            fresh = blit_byte(data_byte_i);
            pixel_expect_q.insert(pixel_expect_q.size(), fresh);
          end
          default: ;
        endcase
      end
      fail_count_o <= fails;
      pending_o    <= pixel_expect_q.size();
    end
  end

endmodule

/* tb/sparse_palette_run_blitter_unit_tb.sv */
// sparse_palette_run_blitter_unit_tb: stimulus, reset and verdict for the run blitter
// depends on sprb_pkg, sparse_palette_run_blitter_unit and sprb_result_check
`timescale 1ns / 100ps

module sparse_palette_run_blitter_unit_tb;

  localparam int unsigned CW = sprb_pkg::CFG_W;
  localparam int unsigned PW = sprb_pkg::POS_W;

  // operation code the block must ignore
  localparam logic [1:0] OP_UNDEFINED = 2'd3;

  localparam int IDLE_LIMIT     = 4000;  // cycles without any handshake before giving up
  localparam int LONG_HOLD      = 300;   // one long receiver hold-off
  localparam int SETTLE         = 10;    // well above the four-stage pipeline depth
  localparam int PAYLOAD_TARGET = 220;   // directed bytes plus about 200 random ones
  localparam int PHASE_BYTES    = 50;    // payload bytes per image setting

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 cfg_we       = 1'b0;
  logic                 cfg_index    = 1'b0;
  logic [CW-1:0]        cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [1:0]           operation    = '0;
  logic [7:0]           palette_index = '0;
  logic [31:0]          palette_color = '0;
  logic signed [31:0]   start_x      = '0;
  logic signed [31:0]   start_y      = '0;
  logic [7:0]           data_byte    = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic                 pixel_valid;
  logic [PW-1:0]        pixel_index;
  logic [31:0]          pixel_value;
  logic                 block_end;
  logic                 bad_size;

  int fail_count;
  int results_pending;

  // sender side bookkeeping
  int img_w         = 640;
  int img_h         = 480;
  int payload_sent  = 0;
  int idle_cycles   = 0;
  bit calm          = 1'b0;  // no gaps and no stalls while set
  bit hold_long     = 1'b0;  // asks the receiver for one long hold-off

  always #5 clk = ~clk;

  sparse_palette_run_blitter_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .operation_i     (operation),
    .palette_index_i (palette_index),
    .palette_color_i (palette_color),
    .start_x_i       (start_x),
    .start_y_i       (start_y),
    .data_byte_i     (data_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .pixel_valid_o   (pixel_valid),
    .pixel_index_o   (pixel_index),
    .pixel_value_o   (pixel_value),
    .block_end_o     (block_end),
    .bad_size_o      (bad_size)
  );

  sprb_result_check result_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .operation_i     (operation),
    .palette_index_i (palette_index),
    .palette_color_i (palette_color),
    .start_x_i       (start_x),
    .start_y_i       (start_y),
    .data_byte_i     (data_byte),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .pixel_valid_i   (pixel_valid),
    .pixel_index_i   (pixel_index),
    .pixel_value_i   (pixel_value),
    .block_end_i     (block_end),
    .bad_size_i      (bad_size),
    .fail_count_o    (fail_count),
    .pending_o       (results_pending)
  );

  // gap before a request: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm)
      return 0;
    if (r < 60)
      return 0;
    if (r < 88)
      return $urandom_range(3, 1);
    if (r < 97)
      return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [31:0] coord_corner();
    case ($urandom_range(3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // offer one request and hold it until the block takes it; valid stays high
  // afterwards so a back-to-back request needs no second assignment in one step
  task automatic push_req(input logic [1:0] op, input logic [7:0] pidx,
                          input logic [31:0] pcol, input logic [31:0] sx,
                          input logic [31:0] sy, input logic [7:0] db);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    palette_index <= pidx;
    palette_color <= pcol;
    start_x       <= sx;
    start_y       <= sy;
    data_byte     <= db;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    if (op == sprb_pkg::OP_PAYLOAD)
      payload_sent++;
  endtask

  // unused fields carry random values so every bit moves
  task automatic send_palette(input logic [7:0] idx, input logic [31:0] colour);
    push_req(sprb_pkg::OP_PALETTE, idx, colour, $urandom(), $urandom(), 8'($urandom()));
  endtask

  task automatic send_start(input logic [31:0] sx, input logic [31:0] sy);
    push_req(sprb_pkg::OP_START, 8'($urandom()), $urandom(), sx, sy, 8'($urandom()));
  endtask

  task automatic send_payload(input logic [7:0] b);
    push_req(sprb_pkg::OP_PAYLOAD, 8'($urandom()), $urandom(), $urandom(), $urandom(), b);
  endtask

  task automatic send_undefined();
    push_req(OP_UNDEFINED, 8'($urandom()), $urandom(), $urandom(), $urandom(),
             8'($urandom()));
  endtask

  // control words go out little-endian
  task automatic send_word(input logic [31:0] w);
    send_payload(w[7:0]);
    send_payload(w[15:8]);
    send_payload(w[23:16]);
    send_payload(w[31:24]);
  endtask

  // stop offering, let every result come back, then give the pipeline time to
  // retire palette writes and block starts, which leave no result behind
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // both registers on back-to-back cycles, only while the block is idle
  task automatic set_image(input int w, input int h);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= sprb_pkg::CFG_IDX_WIDTH;
    cfg_data  <= CW'(w);
    @(posedge clk);
    cfg_index <= sprb_pkg::CFG_IDX_HEIGHT;
    cfg_data  <= CW'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
    img_w = w;
    img_h = h;
  endtask

  // one block: start, a few control words each with its pixel bytes, mostly an
  // end word; now and then the byte count is cut or a stray byte breaks alignment
  task automatic run_block();
    logic [31:0] sx, sy;
    logic [10:0] dx;
    logic [1:0]  flip;
    logic [9:0]  run;
    logic [8:0]  dy;
    logic        alpha;
    int          kind, words, pix_bytes;
    kind = $urandom_range(99);
    if (kind < 60) begin
      // on the image, x may land exactly on the row end
      sx = $urandom_range(img_w > 1023 ? 1023 : img_w);
      sy = $urandom_range(img_h > 32 ? 31 : img_h - 1);
    end else if (kind < 72) begin
      // negative row
      sx = $urandom_range(40);
      sy = 32'd0 - 32'($urandom_range(4, 1));
    end else if (kind < 88) begin
      sx = $urandom();
      sy = $urandom();
    end else begin
      // near the wrap points of the coordinates
      sx = coord_corner();
      sy = coord_corner();
    end
    send_start(sx, sy);
    alpha = 1'b1;
    words = $urandom_range(4, 1);
    repeat (words) begin
      kind = $urandom_range(99);
      dy   = (kind < 70) ? 9'd0 : (kind < 90) ? 9'd1 : 9'($urandom());
      kind = $urandom_range(99);
      dx   = (kind < 70) ? 11'($urandom_range(4)) - 11'd2 : 11'($urandom());
      kind = $urandom_range(99);
      run  = (kind < 70) ? 10'($urandom_range(6)) :
             (kind < 90) ? 10'($urandom_range(20, 7)) : 10'($urandom());
      flip = ($urandom_range(99) < 75) ? 2'b00 : 2'($urandom_range(3, 1));
      send_word({dx, flip, run, dy});
      if (flip != 2'b00)
        alpha = !alpha;
      pix_bytes = int'(run) * (alpha ? 2 : 1);
      if (pix_bytes > 48)
        pix_bytes = $urandom_range(48);
      repeat (pix_bytes) send_payload(8'($urandom()));
      if ($urandom_range(99) < 4)
        send_payload(8'($urandom()));
    end
    if ($urandom_range(99) < 90)
      send_word(sprb_pkg::END_WORD);
    // noise between blocks: palette rewrites, ignored operations, idle bytes
    kind = $urandom_range(99);
    if (kind < 8)
      send_palette(8'($urandom()), $urandom());
    else if (kind < 11)
      send_undefined();
    else if (kind < 16)
      send_payload(8'($urandom()));
  endtask

  // receiver: random stall patterns, one long hold-off on request, none when calm
  initial begin : receiver
    int n;
    @(posedge clk);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
      end else if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < 30);
        n = ($urandom_range(99) < 90) ? $urandom_range(3, 1) : $urandom_range(40, 4);
        repeat (n) @(posedge clk);
      end
    end
  end

  // watchdog: any handshake on either channel restarts the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $error("no request or result accepted for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int phase_no, phase_stop;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole palette so no pixel ever reads an unwritten entry
    send_palette(8'd0, 32'h0000_0000);
    for (int i = 1; i < 255; i++)
      send_palette(8'(i), $urandom());
    send_palette(8'd255, 32'hFFFF_FFFF);

    // directed part at the reset image size 640 x 480
    send_payload(8'hFF);                        // payload while idle
    send_undefined();                           // ignored, no result
    send_start(32'd0, 32'd0);
    send_word({11'd0, 2'b00, 10'd2, 9'd0});     // two alpha pixels at the origin
    send_payload(8'h00);                        // alpha 0 wraps to top byte ff
    send_payload(8'h00);
    send_payload(8'h80);                        // alpha 80 also gives ff
    send_payload(8'hFF);
    send_word({11'd5, 2'b01, 10'd1, 9'd1});     // opaque mode, step right and down
    send_payload(8'h7F);
    send_word(sprb_pkg::END_WORD);
    send_start(32'd640, 32'd0);                 // cursor sits on the row end
    send_word({11'd0, 2'b00, 10'h3FF, 9'h1FF}); // zero-length segment, block dropped
    send_payload(8'h00);                        // error flag stays up while idle

    // random part over several image sizes, the extremes first
    phase_no = 0;
    while (payload_sent < PAYLOAD_TARGET) begin
      case (phase_no)
        0: set_image(1, 1);
        1: set_image(16384, 16384);
        2: begin
          set_image(1024, 12);                  // runs wrap cleanly across rows
          calm = 1'b1;
        end
        3: begin
          set_image(640, 480);
          hold_long = 1'b1;                     // sender keeps going into a full pipe
        end
        default: begin
          if ($urandom_range(3) == 0)
            set_image($urandom_range(1100, 1000), $urandom_range(20, 1));
          else
            set_image($urandom_range(48, 1), $urandom_range(20, 1));
        end
      endcase
      phase_stop = payload_sent + PHASE_BYTES;
      while (payload_sent < phase_stop)
        run_block();
      calm = 1'b0;
      phase_no++;
    end

    drain();
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
